### rtl/lpmd_pkg.sv
`timescale 1ns / 1ps

package lpmd_pkg;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CLS_PREFIX = 2'd0,
        CLS_HEADER = 2'd1,
        CLS_BODY   = 2'd2,
        CLS_ERROR  = 2'd3
    } byte_class_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_BAD_MAGIC   = 2'd1,
        ERR_BAD_HEADER  = 2'd2,
        ERR_BODY_LONG   = 2'd3
    } error_code_t;

    typedef struct packed {
        byte_class_t byte_class;
        logic [7:0]  data_out;
        logic        section_end;
        logic        message_end;
        error_code_t error_code;
    } lpmd_result_t;

    localparam int RESULT_W = $bits(lpmd_result_t);

    localparam logic [7:0] CFG_MAX_HEADER = 8'd0;
    localparam logic [7:0] CFG_MAX_BODY   = 8'd1;

    localparam logic [31:0] DEFAULT_MAX_LENGTH = 32'd10485760;
    localparam logic [3:0]  PREFIX_LAST        = 4'd11;

    localparam logic [7:0] MAGIC [4] = '{8'h53, 8'h4D, 8'h50, 8'h6D};

endpackage

### rtl/lpmd_pipe_reg.sv
`timescale 1ns / 1ps

module lpmd_pipe_reg
    import lpmd_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

endmodule

### rtl/lpmd_parser.sv
`timescale 1ns / 1ps

module lpmd_parser
    import lpmd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         fire,
    input  logic [7:0]   in_byte,
    output lpmd_result_t result
);

    logic [31:0]            max_header_reg;
    logic [31:0]            max_body_reg;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             count_reg, count_next;
    logic                   magic_ok_reg, magic_ok_next;
    logic [LENGTH_BITS-1:0] hdr_len_reg, hdr_len_next;
    logic                   hdr_ovf_reg, hdr_ovf_next;
    logic [LENGTH_BITS-1:0] body_len_reg, body_len_next;
    logic                   body_ovf_reg, body_ovf_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;

    logic [31:0]            placed_byte;
    logic [LENGTH_BITS-1:0] placed_low;
    logic                   placed_ovf;
    logic                   first_byte;
    logic                   magic_ok_new;
    logic [LENGTH_BITS-1:0] hdr_len_new, body_len_new;
    logic                   hdr_ovf_new, body_ovf_new;
    logic                   hdr_bad, body_bad, body_empty;
    logic                   section_last;
    logic                   prefix_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_header_reg <= DEFAULT_MAX_LENGTH;
            max_body_reg   <= DEFAULT_MAX_LENGTH;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_HEADER: max_header_reg <= cfg_data;
                CFG_MAX_BODY:   max_body_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // place the byte at its little-endian lane of the length word
    assign placed_byte = 32'(in_byte) << {count_reg[1:0], 3'b000};
    assign placed_low  = placed_byte[LENGTH_BITS-1:0];
    assign placed_ovf  = |(placed_byte >> LENGTH_BITS);
    assign first_byte  = (count_reg == 4'd0);
    assign prefix_done = (count_reg == PREFIX_LAST);

    always_comb
    begin
        magic_ok_new = first_byte ? 1'b1 : magic_ok_reg;
        hdr_len_new  = first_byte ? '0 : hdr_len_reg;
        hdr_ovf_new  = first_byte ? 1'b0 : hdr_ovf_reg;
        body_len_new = first_byte ? '0 : body_len_reg;
        body_ovf_new = first_byte ? 1'b0 : body_ovf_reg;
        case (count_reg[3:2])
            2'd0:
            begin
                if (in_byte != MAGIC[count_reg[1:0]])
                begin
                    magic_ok_new = 1'b0;
                end
            end
            2'd1:
            begin
                hdr_len_new = hdr_len_new | placed_low;
                hdr_ovf_new = hdr_ovf_new | placed_ovf;
            end
            default:
            begin
                body_len_new = body_len_new | placed_low;
                body_ovf_new = body_ovf_new | placed_ovf;
            end
        endcase
    end

    assign hdr_bad = hdr_ovf_new || (hdr_len_new == '0)
                     || (32'(hdr_len_new) > max_header_reg);
    assign body_bad     = body_ovf_reg || (32'(body_len_reg) > max_body_reg);
    assign body_empty   = (body_len_reg == '0);
    assign section_last = (left_reg <= LENGTH_BITS'(1));

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        magic_ok_next = magic_ok_reg;
        hdr_len_next  = hdr_len_reg;
        hdr_ovf_next  = hdr_ovf_reg;
        body_len_next = body_len_reg;
        body_ovf_next = body_ovf_reg;
        left_next     = left_reg;
        case (phase_reg)
            PH_HEADER:
            begin
                left_next = section_last ? '0 : left_reg - LENGTH_BITS'(1);
                if (section_last)
                begin
                    if (body_bad || body_empty)
                    begin
                        phase_next    = PH_PREFIX;
                        count_next    = 4'd0;
                        magic_ok_next = 1'b1;
                        hdr_len_next  = '0;
                        hdr_ovf_next  = 1'b0;
                        body_len_next = '0;
                        body_ovf_next = 1'b0;
                        left_next     = '0;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        left_next  = body_len_reg;
                    end
                end
            end
            PH_BODY:
            begin
                if (section_last)
                begin
                    phase_next    = PH_PREFIX;
                    count_next    = 4'd0;
                    magic_ok_next = 1'b1;
                    hdr_len_next  = '0;
                    hdr_ovf_next  = 1'b0;
                    body_len_next = '0;
                    body_ovf_next = 1'b0;
                    left_next     = '0;
                end
                else
                begin
                    left_next = left_reg - LENGTH_BITS'(1);
                end
            end
            default:
            begin
                phase_next    = PH_PREFIX;
                count_next    = count_reg + 4'd1;
                magic_ok_next = magic_ok_new;
                hdr_len_next  = hdr_len_new;
                hdr_ovf_next  = hdr_ovf_new;
                body_len_next = body_len_new;
                body_ovf_next = body_ovf_new;
                if (prefix_done)
                begin
                    count_next = 4'd0;
                    if (!magic_ok_new || hdr_bad)
                    begin
                        magic_ok_next = 1'b1;
                        hdr_len_next  = '0;
                        hdr_ovf_next  = 1'b0;
                        body_len_next = '0;
                        body_ovf_next = 1'b0;
                        left_next     = '0;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        left_next  = hdr_len_new;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        result = '{byte_class: CLS_PREFIX, data_out: 8'd0, section_end: 1'b0,
                   message_end: 1'b0, error_code: ERR_NONE};
        case (phase_reg)
            PH_HEADER:
            begin
                if (section_last && body_bad)
                begin
                    result.byte_class = CLS_ERROR;
                    result.error_code = ERR_BODY_LONG;
                end
                else
                begin
                    result.byte_class  = CLS_HEADER;
                    result.data_out    = in_byte;
                    result.section_end = section_last;
                    result.message_end = section_last && body_empty;
                end
            end
            PH_BODY:
            begin
                result.byte_class  = CLS_BODY;
                result.data_out    = in_byte;
                result.section_end = section_last;
                result.message_end = section_last;
            end
            default:
            begin
                if (prefix_done && !magic_ok_new)
                begin
                    result.byte_class = CLS_ERROR;
                    result.error_code = ERR_BAD_MAGIC;
                end
                else if (prefix_done && hdr_bad)
                begin
                    result.byte_class = CLS_ERROR;
                    result.error_code = ERR_BAD_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_PREFIX;
            count_reg    <= 4'd0;
            magic_ok_reg <= 1'b1;
            hdr_len_reg  <= '0;
            hdr_ovf_reg  <= 1'b0;
            body_len_reg <= '0;
            body_ovf_reg <= 1'b0;
            left_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            magic_ok_reg <= magic_ok_next;
            hdr_len_reg  <= hdr_len_next;
            hdr_ovf_reg  <= hdr_ovf_next;
            body_len_reg <= body_len_next;
            body_ovf_reg <= body_ovf_next;
            left_reg     <= left_next;
        end
    end

endmodule

### rtl/length_prefixed_message_deframer.sv
`timescale 1ns / 1ps
// An accepted input byte passes the input register, parser logic and result register.
// Throughput: one byte per cycle while m_axis_tready does not stall the result register.
// Reset (rst_n, asynchronous, active low): wait for a new prefix, clear counters,
// both length limits return to 10485760. cfg_ready is always high.

module length_prefixed_message_deframer
    import lpmd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_out, [9:8] error_code, zero pad
    output logic [2:0]  m_axis_tuser,   // [1:0] byte_class, [2] section_end
    output logic        m_axis_tlast,   // message_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic         s1_valid;
    logic         s1_ready;
    logic [7:0]   s1_byte;
    logic         fire;
    lpmd_result_t result;
    lpmd_result_t out_result;

    assign cfg_ready = 1'b1;
    assign fire      = s1_valid && s1_ready;

    lpmd_pipe_reg #(
        .WIDTH (8)
    ) u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_byte)
    );

    lpmd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .in_byte   (s1_byte),
        .result    (result)
    );

    lpmd_pipe_reg #(
        .WIDTH (RESULT_W)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = {6'd0, out_result.error_code, out_result.data_out};
    assign m_axis_tuser = {out_result.section_end, out_result.byte_class};
    assign m_axis_tlast = out_result.message_end;

    a_error_code_class: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tuser[1:0] == CLS_ERROR) == (m_axis_tdata[9:8] != ERR_NONE)))
        else $error("error code and byte class disagree");

    a_message_end_section: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[2])
        else $error("message end without section end");

    a_flags_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |->
            (m_axis_tuser[1:0] == CLS_HEADER || m_axis_tuser[1:0] == CLS_BODY))
        else $error("section end on a prefix or error byte");

    a_stall_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && m_axis_tvalid && !m_axis_tready) |=> $stable(u_parser.phase_reg))
        else $error("parser advanced while result stage stalled");

endmodule

### tb/length_prefixed_message_deframer_tb.sv
`timescale 1ns / 1ps

module length_prefixed_message_deframer_tb;
    import lpmd_pkg::*;

    localparam int LEN_BITS = 32;
    localparam logic [31:0] MAGIC_WORD = {MAGIC[3], MAGIC[2], MAGIC[1], MAGIC[0]};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = CFG_MAX_HEADER;
    logic [31:0] cfg_data = 32'd0;

    logic [7:0]   stream_bytes[$];
    lpmd_result_t deframed_q[$];
    int           byte_count = 0;
    int           fail_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic [31:0]  lim_hdr = DEFAULT_MAX_LENGTH;
    logic [31:0]  lim_body = DEFAULT_MAX_LENGTH;

    phase_t      ph = PH_PREFIX;
    logic [3:0]  pfx_cnt = 4'd0;
    logic        magic_good = 1'b1;
    logic [31:0] hdr_len = 32'd0;
    logic [31:0] body_len = 32'd0;
    logic [31:0] left = 32'd0;
    logic [31:0] max_hdr = DEFAULT_MAX_LENGTH;
    logic [31:0] max_body = DEFAULT_MAX_LENGTH;

    length_prefixed_message_deframer #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic too_wide(logic [31:0] len);
        return 64'(len) > ((64'd1 << LEN_BITS) - 64'd1);
    endfunction

    function automatic void restart_frame();
        ph = PH_PREFIX;
        pfx_cnt = 4'd0;
        magic_good = 1'b1;
        hdr_len = 32'd0;
        body_len = 32'd0;
        left = 32'd0;
    endfunction

    function automatic lpmd_result_t deframe_byte(logic [7:0] b);
        lpmd_result_t r;
        logic last;
        r = '0;
        case (ph)
            PH_HEADER:
            begin
                last = (left <= 32'd1);
                left = last ? 32'd0 : left - 32'd1;
                if (!last)
                begin
                    r.byte_class = CLS_HEADER;
                    r.data_out = b;
                end
                else if (too_wide(body_len) || body_len > max_body)
                begin
                    restart_frame();
                    r.byte_class = CLS_ERROR;
                    r.error_code = ERR_BODY_LONG;
                end
                else
                begin
                    r.byte_class = CLS_HEADER;
                    r.data_out = b;
                    r.section_end = 1'b1;
                    if (body_len == 32'd0)
                    begin
                        restart_frame();
                        r.message_end = 1'b1;
                    end
                    else
                    begin
                        ph = PH_BODY;
                        left = body_len;
                    end
                end
            end
            PH_BODY:
            begin
                r.byte_class = CLS_BODY;
                r.data_out = b;
                if (left <= 32'd1)
                begin
                    restart_frame();
                    r.section_end = 1'b1;
                    r.message_end = 1'b1;
                end
                else
                begin
                    left = left - 32'd1;
                end
            end
            default:
            begin
                if (ph != PH_PREFIX || pfx_cnt > PREFIX_LAST)
                    restart_frame();
                if (pfx_cnt == 4'd0)
                begin
                    magic_good = 1'b1;
                    hdr_len = 32'd0;
                    body_len = 32'd0;
                end
                if (pfx_cnt < 4'd4)
                begin
                    if (b != MAGIC[pfx_cnt[1:0]])
                        magic_good = 1'b0;
                end
                else if (pfx_cnt < 4'd8)
                    hdr_len = hdr_len | (32'(b) << {pfx_cnt[1:0], 3'b000});
                else
                    body_len = body_len | (32'(b) << {pfx_cnt[1:0], 3'b000});
                if (pfx_cnt == PREFIX_LAST)
                begin
                    if (!magic_good)
                    begin
                        restart_frame();
                        r.byte_class = CLS_ERROR;
                        r.error_code = ERR_BAD_MAGIC;
                    end
                    else if (hdr_len == 32'd0 || hdr_len > max_hdr || too_wide(hdr_len))
                    begin
                        restart_frame();
                        r.byte_class = CLS_ERROR;
                        r.error_code = ERR_BAD_HEADER;
                    end
                    else
                    begin
                        ph = PH_HEADER;
                        pfx_cnt = 4'd0;
                        left = hdr_len;
                    end
                end
                else
                begin
                    pfx_cnt = pfx_cnt + 4'd1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= stream_bytes.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and prediction
    always @(posedge clk)
    begin
        lpmd_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_HEADER: max_hdr = cfg_data;
                    CFG_MAX_BODY:   max_body = cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (deframed_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = deframed_q.pop_front();
                    check_field("byte_class", want.byte_class, m_axis_tuser[1:0]);
                    check_field("data_out", want.data_out, m_axis_tdata[7:0]);
                    check_field("section_end", want.section_end, m_axis_tuser[2]);
                    check_field("message_end", want.message_end, m_axis_tlast);
                    check_field("error_code", want.error_code, m_axis_tdata[9:8]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                deframed_q.push_back(deframe_byte(s_axis_tdata));
        end
    end

    task automatic put_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
        byte_count++;
    endtask

    task automatic push_payload(input int n);
        repeat (n) put_byte(8'($urandom_range(255)));
    endtask

    task automatic push_prefix(input logic [31:0] magic_word, input logic [31:0] hdr,
                               input logic [31:0] body);
        for (int i = 0; i < 4; i++) put_byte(magic_word[8*i +: 8]);
        for (int i = 0; i < 4; i++) put_byte(hdr[8*i +: 8]);
        for (int i = 0; i < 4; i++) put_byte(body[8*i +: 8]);
    endtask

    task automatic random_frame();
        int pick;
        logic [7:0]  b;
        logic [31:0] hdr;
        logic [31:0] body;
        logic [31:0] hdr_cap;
        logic [31:0] body_cap;
        pick = $urandom_range(99);
        hdr_cap = (lim_hdr < 32'd12) ? lim_hdr : 32'd12;
        body_cap = (lim_body < 32'd12) ? lim_body : 32'd12;
        hdr = $urandom_range(hdr_cap, 1);
        body = $urandom_range(body_cap, 0);
        if (pick < 70)
        begin
            push_prefix(MAGIC_WORD, hdr, body);
            push_payload(hdr + body);
        end
        else if (pick < 76)
        begin
            push_prefix(MAGIC_WORD ^ (32'd1 << $urandom_range(31)), $urandom, $urandom);
        end
        else if (pick < 81)
        begin
            push_prefix(MAGIC_WORD, 32'd0, body);
        end
        else if (pick < 87)
        begin
            hdr = $urandom;
            if (hdr <= lim_hdr)
                hdr = (lim_hdr == '1) ? 32'd0 : lim_hdr + 32'd1;
            push_prefix(MAGIC_WORD, hdr, body);
        end
        else if (pick < 94)
        begin
            if (lim_body == '1)
            begin
                push_prefix(MAGIC_WORD, hdr, body);
                push_payload(hdr + body);
            end
            else
            begin
                body = $urandom;
                if (body <= lim_body)
                    body = lim_body + 32'd1;
                push_prefix(MAGIC_WORD, hdr, body);
                push_payload(hdr);
            end
        end
        else
        begin
            // keep noise in whole prefix lengths that never open with a valid magic
            repeat ($urandom_range(2, 1))
            begin
                b = 8'($urandom_range(255));
                if (b == MAGIC[0])
                    b = b ^ 8'h01;
                put_byte(b);
                push_payload(11);
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (stream_bytes.size() != 0 || s_axis_tvalid || deframed_q.size() != 0);
    endtask

    task automatic write_limit(input logic [7:0] index, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_MAX_HEADER)
            lim_hdr = value;
        else
            lim_body = value;
    endtask

    task automatic run_phase(input int send_pct, input int stall_pct, input int n_bytes,
                             input bit pause_midway);
        int start;
        bit paused;
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        start = byte_count;
        paused = 1'b0;
        while (byte_count - start < n_bytes)
        begin
            random_frame();
            // hold the sender until every request is answered
            if (pause_midway && !paused && byte_count - start >= n_bytes / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        push_prefix(MAGIC_WORD, 32'd1, 32'd0);
        put_byte(8'hFF);
        push_prefix(MAGIC_WORD, 32'd2, 32'd2);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'hFF);
        push_prefix({8'h4D, MAGIC_WORD[23:0]}, 32'd0, 32'd0);
        push_prefix(MAGIC_WORD, 32'd0, 32'd3);
        push_prefix(MAGIC_WORD, DEFAULT_MAX_LENGTH + 32'd1, 32'd0);
        push_prefix(MAGIC_WORD, 32'd1, DEFAULT_MAX_LENGTH + 32'd1);
        put_byte(8'hAA);
        wait_idle();

        write_limit(CFG_MAX_HEADER, 32'd1);
        write_limit(CFG_MAX_BODY, 32'd0);
        run_phase(69, 0, 300, 1'b0);

        write_limit(CFG_MAX_HEADER, 32'hFFFF_FFFF);
        write_limit(CFG_MAX_BODY, 32'hFFFF_FFFF);
        run_phase(0, 69, 300, 1'b0);

        write_limit(CFG_MAX_HEADER, 32'd16);
        write_limit(CFG_MAX_BODY, 32'd24);
        run_phase(37, 37, 300, 1'b0);

        write_limit(CFG_MAX_HEADER, 32'd8);
        write_limit(CFG_MAX_BODY, 32'd5);
        run_phase(0, 0, 300, 1'b1);

        repeat (10) @(posedge clk);
        if (fail_count == 0 && deframed_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/lpmd_pkg.sv
rtl/lpmd_pipe_reg.sv
rtl/lpmd_parser.sv
rtl/length_prefixed_message_deframer.sv
tb/length_prefixed_message_deframer_tb.sv
